[src/palette_tint_nearest_color_assert.svh]
// Assertion macros used by the checker file of the palette tint block.
`ifndef PALETTE_TINT_NEAREST_COLOR_ASSERT_SVH
`define PALETTE_TINT_NEAREST_COLOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define PTNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define PTNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// In the cycle after the antecedent, with reset itself allowed as the antecedent.
`define PTNC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/ptnc_pkg.sv]
// Shared types, constants and the color class table of the palette tint block.
package ptnc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int CSR_ADDR_W      = 4;
   localparam int DIST_W          = 21;

   localparam int RMEAN_BASE_R = 512;
   localparam int RMEAN_BASE_B = 767;
   localparam int PCT_FULL     = 100;
   localparam int COMP_MAX     = 255;
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;

   localparam logic [7:0] OVR_HIGH = 8'd109;
   localparam logic [7:0] OVR_LOW  = 8'd77;
   localparam logic [7:0] OVR_NEXT = 8'd78;

   localparam logic [6:0] BLEND_PERCENT_RESET = 7'd50;
   localparam logic       ADDITIVE_MODE_RESET = 1'b1;
   localparam logic [3:0] CLASS_MASK_RESET    = 4'd0;

   localparam logic [3:0] CLS_RED   = 4'b0001;
   localparam logic [3:0] CLS_WHITE = 4'b0010;
   localparam logic [3:0] CLS_GREEN = 4'b0100;
   localparam logic [3:0] CLS_BLUE  = 4'b1000;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_TINT    = 2'd1,
      REQ_NEAREST = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [6:0] blend_percent;
      logic       additive_mode;
      logic [3:0] class_mask;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic write_entry;
      logic scan_start;
      logic read_fore;
      logic read_back;
      logic cap_fore;
      logic cap_back;
      logic mix;
      logic quot;
      logic take_short;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic shortcut;
      logic scan_done;
   } stat_type;

   function automatic logic [3:0] class_rom(input logic [7:0] idx);
      logic [3:0] cls;
      cls = '0;
      if (idx == 8'd4 || idx == 8'd224 || idx == 8'd225) begin
         cls = CLS_RED | CLS_BLUE;
      end else if ((idx >= 8'd16 && idx <= 8'd47) || idx == 8'd80) begin
         cls = CLS_RED;
      end else if (idx >= 8'd48 && idx <= 8'd63) begin
         cls = CLS_WHITE;
      end else if (idx >= 8'd112 && idx <= 8'd127) begin
         cls = CLS_GREEN;
      end else if ((idx >= 8'd192 && idx <= 8'd207) || (idx >= 8'd240 && idx <= 8'd247)) begin
         cls = CLS_BLUE;
      end else if ((idx >= 8'd160 && idx <= 8'd223) || (idx >= 8'd226 && idx <= 8'd231)
                   || idx == 8'd248 || idx == 8'd249) begin
         cls = CLS_RED;
      end
      return cls;
   endfunction

endpackage

[src/ptnc_csr.sv]
// Configuration registers behind the APB-style port.
module ptnc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ptnc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output ptnc_pkg::cfg_type                cfg
);

   typedef enum logic [1:0] {
      CSR_BLEND_PERCENT = 2'd0,
      CSR_ADDITIVE_MODE = 2'd1,
      CSR_CLASS_MASK    = 2'd2
   } csr_index_type;

   ptnc_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_BLEND_PERCENT: cfg_in.blend_percent = csr_pwdata[6:0];
            CSR_ADDITIVE_MODE: cfg_in.additive_mode = csr_pwdata[0];
            CSR_CLASS_MASK:    cfg_in.class_mask    = csr_pwdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_BLEND_PERCENT: csr_prdata = {25'd0, cfg_ff.blend_percent};
         CSR_ADDITIVE_MODE: csr_prdata = {31'd0, cfg_ff.additive_mode};
         CSR_CLASS_MASK:    csr_prdata = {28'd0, cfg_ff.class_mask};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blend_percent <= ptnc_pkg::BLEND_PERCENT_RESET;
         cfg_ff.additive_mode <= ptnc_pkg::ADDITIVE_MODE_RESET;
         cfg_ff.class_mask    <= ptnc_pkg::CLASS_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/ptnc_ctrl.sv]
// Sequencer that steps writes, tint lookups and palette searches.
module ptnc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  ptnc_pkg::stat_type  stat,
   output ptnc_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_BACK,
      ST_CAP_BACK,
      ST_MIX,
      ST_QUOT,
      ST_SCAN_START,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  ptnc_pkg::REQ_WRITE:   cmd.write_entry = 1'b1;
                  ptnc_pkg::REQ_TINT:    state_in = ST_CHECK;
                  ptnc_pkg::REQ_NEAREST: state_in = ST_SCAN_START;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK: begin
            if (stat.shortcut) begin
               cmd.take_short = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               cmd.read_fore = 1'b1;
               state_in      = ST_RD_BACK;
            end
         end
         ST_RD_BACK: begin
            cmd.read_back = 1'b1;
            cmd.cap_fore  = 1'b1;
            state_in      = ST_CAP_BACK;
         end
         ST_CAP_BACK: begin
            cmd.cap_back = 1'b1;
            state_in     = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            cmd.quot = 1'b1;
            state_in = ST_SCAN_START;
         end
         ST_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The result waits here while the previous transaction is still unread.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/ptnc_datapath.sv]
// Palette memory, color blend, redmean distance pipeline and best-match tracking.
module ptnc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ptnc_pkg::cmd_type  cmd,
   output ptnc_pkg::stat_type stat,
   input  ptnc_pkg::cfg_type  cfg,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_fore_index,
   input  logic [7:0]         req_back_index,
   output logic [7:0]         rsp_color_index
);

   localparam int IDX_W  = ptnc_pkg::IDX_W;
   localparam int DIST_W = ptnc_pkg::DIST_W;

   logic [23:0] mem [ptnc_pkg::PALETTE_ENTRIES];

   logic [7:0] tgt_ff [3];
   logic [7:0] fore_ff, back_ff;
   logic [7:0] fore_col_ff [3];
   logic [7:0] back_col_ff [3];
   logic [14:0] wsum_ff [3];
   logic [14:0] wsum_in [3];
   logic [7:0] add_ff [3];
   logic [7:0] add_in [3];
   logic [7:0] mix_in [3];
   logic [27:0] qprod [3];
   logic [8:0] asum [3];
   logic [6:0] pct, inv;

   logic [23:0]     rd_data_ff;
   logic            rd_oob_ff;
   logic            rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic             scan_busy_ff;
   logic [IDX_W-1:0] scan_addr_ff;

   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [15:0]      sq_r_ff, sq_g_ff, sq_b_ff;
   logic [7:0]       rmean_ff;
   logic [25:0]      prod_r_ff, prod_b_ff;
   logic [15:0]      g_term_ff;

   logic signed [8:0]  dr, dg, db;
   logic signed [17:0] sq_r_full, sq_g_full, sq_b_full;
   logic [8:0]         rsum;
   logic [9:0]         wr, wb;
   logic [DIST_W-1:0]  cand_dist;
   logic               better;

   logic             first_ff;
   logic [IDX_W-1:0] best_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic [7:0]       res_ff;
   logic [7:0]       rsp_ff;

   logic       short_hit;
   logic [7:0] short_val;
   logic [3:0] fore_cls;

   assign rsp_color_index = rsp_ff;

   // Palette write port.
   always_ff @(posedge clock) begin
      if (cmd.write_entry && ({1'b0, req_entry_index} < 9'(ptnc_pkg::PALETTE_ENTRIES))) begin
         mem[req_entry_index[IDX_W-1:0]] <= {req_red, req_green, req_blue};
      end
   end

   // Single registered read port shared by the scan and the tint color fetch.
   always_comb begin
      rd_en   = scan_busy_ff || cmd.read_fore || cmd.read_back;
      rd_addr = scan_addr_ff;
      if (cmd.read_fore) begin
         rd_addr = fore_ff[IDX_W-1:0];
      end else if (cmd.read_back) begin
         rd_addr = back_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      rd_oob_ff <= (cmd.read_fore && ({1'b0, fore_ff} >= 9'(ptnc_pkg::PALETTE_ENTRIES)))
                || (cmd.read_back && ({1'b0, back_ff} >= 9'(ptnc_pkg::PALETTE_ENTRIES)));
   end

   // Request capture and tint blend.
   assign pct = (cfg.blend_percent > 7'(ptnc_pkg::PCT_FULL)) ? 7'(ptnc_pkg::PCT_FULL)
                                                            : cfg.blend_percent;
   assign inv = 7'(ptnc_pkg::PCT_FULL) - pct;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wsum_in[k] = 15'(back_col_ff[k] * pct) + 15'(fore_col_ff[k] * inv);
         asum[k]    = {1'b0, fore_col_ff[k]} + {1'b0, back_col_ff[k]};
         add_in[k]  = asum[k][8] ? 8'(ptnc_pkg::COMP_MAX) : asum[k][7:0];
         // Floor of the quotient by one hundred through a scaled reciprocal.
         qprod[k]   = wsum_ff[k] * 13'(ptnc_pkg::DIV100_MUL);
         mix_in[k]  = cfg.additive_mode ? add_ff[k]
                                        : qprod[k][ptnc_pkg::DIV100_SHIFT +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tgt_ff[0] <= req_red;
         tgt_ff[1] <= req_green;
         tgt_ff[2] <= req_blue;
         fore_ff   <= req_fore_index;
         back_ff   <= req_back_index;
      end
      for (int k = 0; k < 3; k++) begin
         if (cmd.cap_fore) begin
            fore_col_ff[k] <= rd_oob_ff ? 8'd0 : rd_data_ff[23 - 8 * k -: 8];
         end
         if (cmd.cap_back) begin
            back_col_ff[k] <= rd_oob_ff ? 8'd0 : rd_data_ff[23 - 8 * k -: 8];
         end
         if (cmd.mix) begin
            wsum_ff[k] <= wsum_in[k];
            add_ff[k]  <= add_in[k];
         end
         if (cmd.quot) begin
            tgt_ff[k] <= mix_in[k];
         end
      end
   end

   // Foreground class filter and the fixed pair overrides.
   always_comb begin
      fore_cls  = ptnc_pkg::class_rom(fore_ff);
      short_hit = 1'b0;
      short_val = fore_ff;
      if (cfg.class_mask != 4'd0 && (fore_cls & cfg.class_mask) == 4'd0) begin
         short_hit = 1'b1;
      end else if (cfg.class_mask == 4'd0 && !cfg.additive_mode) begin
         if ((fore_ff == ptnc_pkg::OVR_HIGH && back_ff == ptnc_pkg::OVR_LOW)
             || (fore_ff == ptnc_pkg::OVR_LOW && back_ff == ptnc_pkg::OVR_HIGH)) begin
            short_hit = 1'b1;
            short_val = ptnc_pkg::OVR_LOW;
         end else if ((fore_ff == ptnc_pkg::OVR_HIGH && back_ff == ptnc_pkg::OVR_NEXT)
                      || (fore_ff == ptnc_pkg::OVR_NEXT && back_ff == ptnc_pkg::OVR_HIGH)) begin
            short_hit = 1'b1;
            short_val = ptnc_pkg::OVR_HIGH;
         end
      end
   end

   // Distance pipeline: read, squares, weights, sum and compare.
   always_comb begin
      dr        = $signed({1'b0, tgt_ff[0]}) - $signed({1'b0, rd_data_ff[23:16]});
      dg        = $signed({1'b0, tgt_ff[1]}) - $signed({1'b0, rd_data_ff[15:8]});
      db        = $signed({1'b0, tgt_ff[2]}) - $signed({1'b0, rd_data_ff[7:0]});
      sq_r_full = dr * dr;
      sq_g_full = dg * dg;
      sq_b_full = db * db;
      rsum      = {1'b0, tgt_ff[0]} + {1'b0, rd_data_ff[23:16]};
      wr        = 10'(ptnc_pkg::RMEAN_BASE_R) + {2'b00, rmean_ff};
      wb        = 10'(ptnc_pkg::RMEAN_BASE_B) - {2'b00, rmean_ff};
      cand_dist = DIST_W'(prod_r_ff[25:8]) + DIST_W'({g_term_ff, 2'b00})
                + DIST_W'(prod_b_ff[25:8]);
      better    = first_ff || (cand_dist < best_dist_ff);
   end

   always_ff @(posedge clock) begin
      sq_r_ff   <= sq_r_full[15:0];
      sq_g_ff   <= sq_g_full[15:0];
      sq_b_ff   <= sq_b_full[15:0];
      rmean_ff  <= rsum[8:1];
      s2_idx_ff <= s1_idx_ff;
      prod_r_ff <= wr * sq_r_ff;
      prod_b_ff <= wb * sq_b_ff;
      g_term_ff <= sq_g_ff;
      s3_idx_ff <= s2_idx_ff;
      s1_idx_ff <= scan_addr_ff;
      if (s3_valid_ff && better) begin
         best_ff      <= s3_idx_ff;
         best_dist_ff <= cand_dist;
      end
   end

   assign stat.scan_done = s3_valid_ff && (s3_idx_ff == IDX_W'(ptnc_pkg::PALETTE_ENTRIES - 1));
   assign stat.shortcut  = short_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         scan_addr_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= scan_busy_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (cmd.scan_start) begin
            scan_busy_ff <= 1'b1;
            scan_addr_ff <= '0;
            first_ff     <= 1'b1;
         end else begin
            if (scan_busy_ff) begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
               if (scan_addr_ff == IDX_W'(ptnc_pkg::PALETTE_ENTRIES - 1)) begin
                  scan_busy_ff <= 1'b0;
               end
            end
            if (s3_valid_ff) begin
               first_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_short) begin
         res_ff <= short_val;
      end else if (stat.scan_done) begin
         res_ff <= better ? 8'(s3_idx_ff) : 8'(best_ff);
      end
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

endmodule

[src/palette_tint_nearest_color.sv]
// Top level of the palette tint and nearest color block.
//
// Usage: the request channel (req_valid/req_ready) carries one transaction
// per palette write, tint lookup or nearest color query, chosen by req_type.
// The response channel (rsp_valid/rsp_ready) returns rsp_color_index for
// tint and nearest transactions; writes and the unused type give nothing.
// Configuration goes through the csr_ port while the block is idle.
//
// A write completes on acceptance and the next transaction can follow at once.
// A nearest query reads every palette entry, one per cycle from the single
// memory read port into a four-stage distance pipeline, and the response
// follows the compare of the last entry.
// A tint lookup first fetches and blends the two colors, in the states
// ST_CHECK to ST_QUOT, before the same scan; a tint that the class filter or
// a fixed pair settles skips both. One query is in work at a time.
// Reset returns the sequencer to idle, drops rsp_valid and restores the
// register defaults; palette contents are left as they are and must be
// written before the first query. When the receiver stalls, the finished
// result waits in the output register and the next result waits behind it.
module palette_tint_nearest_color (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [7:0]                      req_entry_index,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_blue,
   input  logic [7:0]                      req_fore_index,
   input  logic [7:0]                      req_back_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_color_index,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ptnc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   ptnc_pkg::cfg_type  cfg;
   ptnc_pkg::cmd_type  cmd;
   ptnc_pkg::stat_type stat;

   ptnc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ptnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptnc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cfg             (cfg),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_fore_index  (req_fore_index),
      .req_back_index  (req_back_index),
      .rsp_color_index (rsp_color_index)
   );

endmodule

[src/ptnc_checker.sv]
// Port-level checks of the palette tint block and their binding to the top level.
`include "palette_tint_nearest_color_assert.svh"

module ptnc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_color_index
);

   `PTNC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_color_index), "stalled response changed")
   `PTNC_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "response valid after reset")
   `PTNC_ASSERT_NOW(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "response without work in progress")
   `PTNC_ASSERT_NEXT(a_write_fast, clock, reset, req_valid && req_ready && (req_type == ptnc_pkg::REQ_WRITE), req_ready, "palette write stalled the request channel")
   `PTNC_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && (req_type == ptnc_pkg::REQ_NEAREST), !req_ready, "nearest query did not start a search")

endmodule

bind palette_tint_nearest_color ptnc_checker u_ptnc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_color_index (rsp_color_index)
);

[tb/tb_palette_tint_nearest_color.sv]
// Self-checking testbench for the palette tint and nearest color block.
module tb_palette_tint_nearest_color;

   localparam int TIMEOUT_CYCLES   = 600000;
   localparam int SETTLE_CYCLES    = 300;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int PHASE_ITEMS      = 36;
   localparam int NUM_PHASES       = 9;

   localparam int REG_BLEND_PERCENT = 0;
   localparam int REG_ADDITIVE_MODE = 1;
   localparam int REG_CLASS_MASK    = 2;
   localparam int REG_SPARE         = 3;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [7:0] PAIR_HIGH = 8'd109;
   localparam logic [7:0] PAIR_LOW  = 8'd77;
   localparam logic [7:0] PAIR_NEXT = 8'd78;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] entry;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] fore;
      logic [7:0] back;
   } palette_req_type;

   typedef struct packed {
      int         serial;
      logic [7:0] color;
   } color_due_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [1:0]                      req_type = ptnc_pkg::REQ_WRITE;
   logic [7:0]                      req_entry_index = '0;
   logic [7:0]                      req_red = '0;
   logic [7:0]                      req_green = '0;
   logic [7:0]                      req_blue = '0;
   logic [7:0]                      req_fore_index = '0;
   logic [7:0]                      req_back_index = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_color_index;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ptnc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   // Shadow of the palette and of the registers, updated as transactions are accepted.
   logic [23:0] palette_shadow [0:ptnc_pkg::PALETTE_ENTRIES-1];
   logic [3:0]  class_bits [0:255];
   logic [6:0]  cfg_percent = 7'd50;
   logic        cfg_additive = 1'b1;
   logic [3:0]  cfg_mask = 4'd0;

   palette_req_type pending_q [$];
   color_due_type   due_q [$];

   int mismatches = 0;
   int results_seen = 0;
   int serial_no = 0;
   int writes_taken = 0;
   int tints_taken = 0;
   int nearest_taken = 0;
   int ignored_taken = 0;

   int phase_pct  [0:NUM_PHASES-1] = '{50, 0, 100, 127, 101, 30, 64, 13, 88};
   int phase_add  [0:NUM_PHASES-1] = '{0, 0, 0, 0, 0, 1, 0, 0, 1};
   int phase_mask [0:NUM_PHASES-1] = '{0, 0, 0, 15, 0, 1, 6, 8, 2};

   logic [7:0] coarse_level [0:4]  = '{8'd0, 8'd64, 8'd128, 8'd192, 8'd255};
   logic [7:0] pair_idx [0:2]      = '{PAIR_LOW, PAIR_NEXT, PAIR_HIGH};
   logic [7:0] border_idx [0:13]   = '{8'd4, 8'd16, 8'd47, 8'd48, 8'd63, 8'd80, 8'd112,
                                       8'd127, 8'd160, 8'd224, 8'd231, 8'd240, 8'd249, 8'd250};

   palette_tint_nearest_color uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic mark_class(input int lo, input int hi, input logic [3:0] bits);
      for (int i = lo; i <= hi; i++) begin
         class_bits[i] = class_bits[i] | bits;
      end
   endtask

   // Redmean distance without the square root; the lowest index wins a tie.
   function automatic logic [7:0] closest_entry(input int r, input int g, input int b);
      int best_idx;
      int best_dist;
      int pr;
      int pg;
      int pb;
      int rmean;
      int entry_dist;
      best_idx = 0;
      best_dist = 32'h7fffffff;
      for (int i = 0; i < ptnc_pkg::PALETTE_ENTRIES; i++) begin
         pr = int'(palette_shadow[i][23:16]);
         pg = int'(palette_shadow[i][15:8]);
         pb = int'(palette_shadow[i][7:0]);
         rmean = (r + pr) / 2;
         entry_dist = (((512 + rmean) * (r - pr) * (r - pr)) >>> 8)
                    + 4 * (g - pg) * (g - pg)
                    + (((767 - rmean) * (b - pb) * (b - pb)) >>> 8);
         if (entry_dist < best_dist) begin
            best_dist = entry_dist;
            best_idx = i;
         end
      end
      return 8'(best_idx);
   endfunction

   function automatic logic [7:0] tint_result(input logic [7:0] fore, input logic [7:0] back);
      int fore_c;
      int back_c;
      int pct;
      int mix [3];
      if (cfg_mask != 4'd0 && (class_bits[fore] & cfg_mask) == 4'd0) begin
         return fore;
      end
      // With every class selected in percent mode, two fixed pairs skip the search.
      if (cfg_mask == 4'd0 && !cfg_additive) begin
         if ((fore == PAIR_HIGH && back == PAIR_LOW) || (fore == PAIR_LOW && back == PAIR_HIGH)) begin
            return PAIR_LOW;
         end
         if ((fore == PAIR_HIGH && back == PAIR_NEXT) || (fore == PAIR_NEXT && back == PAIR_HIGH)) begin
            return PAIR_HIGH;
         end
      end
      pct = (cfg_percent > 7'd100) ? 100 : int'(cfg_percent);
      for (int k = 0; k < 3; k++) begin
         fore_c = int'(palette_shadow[fore][23 - 8 * k -: 8]);
         back_c = int'(palette_shadow[back][23 - 8 * k -: 8]);
         if (cfg_additive) begin
            mix[k] = (fore_c + back_c > 255) ? 255 : fore_c + back_c;
         end else begin
            mix[k] = (back_c * pct + fore_c * (100 - pct)) / 100;
         end
      end
      return closest_entry(mix[0], mix[1], mix[2]);
   endfunction

   function automatic palette_req_type noise_req(input logic [1:0] kind);
      palette_req_type t;
      t.kind  = kind;
      t.entry = 8'($urandom);
      t.red   = 8'($urandom);
      t.green = 8'($urandom);
      t.blue  = 8'($urandom);
      t.fore  = 8'($urandom);
      t.back  = 8'($urandom);
      return t;
   endfunction

   function automatic palette_req_type write_req(input logic [7:0] idx, input logic [23:0] rgb);
      palette_req_type t;
      t = noise_req(ptnc_pkg::REQ_WRITE);
      t.entry = idx;
      {t.red, t.green, t.blue} = rgb;
      return t;
   endfunction

   function automatic palette_req_type nearest_req(input logic [23:0] rgb);
      palette_req_type t;
      t = noise_req(ptnc_pkg::REQ_NEAREST);
      {t.red, t.green, t.blue} = rgb;
      return t;
   endfunction

   function automatic palette_req_type tint_req(input logic [7:0] fore, input logic [7:0] back);
      palette_req_type t;
      t = noise_req(ptnc_pkg::REQ_TINT);
      t.fore = fore;
      t.back = back;
      return t;
   endfunction

   task automatic csr_write(input int idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ptnc_pkg::CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_BLEND_PERCENT: cfg_percent = value[6:0];
         REG_ADDITIVE_MODE: cfg_additive = value[0];
         REG_CLASS_MASK:    cfg_mask = value[3:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Waits until the block has nothing left to do, then idles for a settle period.
   task automatic settle_block();
      while (pending_q.size() != 0 || req_valid || due_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: presents queued transactions in bursts separated by random gaps.
   int              burst_left = 0;
   int              gap_left = 0;
   palette_req_type shown;

   always @(posedge clock) begin : drive_proc
      palette_req_type nxt;
      color_due_type   due;
      logic            fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            serial_no++;
            due.serial = serial_no;
            case (shown.kind)
               ptnc_pkg::REQ_WRITE: begin
                  palette_shadow[shown.entry] = {shown.red, shown.green, shown.blue};
                  writes_taken++;
               end
               ptnc_pkg::REQ_TINT: begin
                  due.color = tint_result(shown.fore, shown.back);
                  due_q.push_back(due);
                  tints_taken++;
               end
               ptnc_pkg::REQ_NEAREST: begin
                  due.color = closest_entry(int'(shown.red), int'(shown.green), int'(shown.blue));
                  due_q.push_back(due);
                  nearest_taken++;
               end
               default: ignored_taken++;
            endcase
         end
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               shown = nxt;
               req_type        <= nxt.kind;
               req_entry_index <= nxt.entry;
               req_red         <= nxt.red;
               req_green       <= nxt.green;
               req_blue        <= nxt.blue;
               req_fore_index  <= nxt.fore;
               req_back_index  <= nxt.back;
               req_valid       <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(9) == 0) ? int'($urandom_range(200, 80))
                                                         : int'($urandom_range(30, 1));
                  gap_left = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(30, 1));
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result collector: checks each response and stalls on its own run-length pattern.
   int run_left = 0;
   int hold_left = 0;
   bit ready_phase = 1'b1;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin : collect_proc
      color_due_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (due_q.size() == 0) begin
               report_mismatch($sformatf("color index %0d arrived with nothing pending",
                                         rsp_color_index));
            end else begin
               want = due_q.pop_front();
               if (rsp_color_index !== want.color) begin
                  report_mismatch($sformatf("transaction %0d: color index %0d, expected %0d",
                                            want.serial, rsp_color_index, want.color));
               end
            end
         end
         // One long hold while requests keep coming, so that the block backs up.
         if (!long_hold_done && results_seen >= 60 && pending_q.size() > 8) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left <= 0) begin
               ready_phase = ($urandom_range(99) < 65);
               run_left = ready_phase ? int'($urandom_range(200, 1)) : int'($urandom_range(25, 1));
            end
            run_left--;
            rsp_ready <= ready_phase;
         end
      end
   end

   initial begin : stimulus_proc
      logic [23:0] fill_rgb [0:255];
      logic [23:0] rgb;
      logic [7:0]  fore_pick;
      logic [7:0]  back_pick;
      int          pick;
      for (int i = 0; i < 256; i++) begin
         class_bits[i] = 4'd0;
      end
      mark_class(4, 4, ptnc_pkg::CLS_RED | ptnc_pkg::CLS_BLUE);
      mark_class(16, 47, ptnc_pkg::CLS_RED);
      mark_class(48, 63, ptnc_pkg::CLS_WHITE);
      mark_class(80, 80, ptnc_pkg::CLS_RED);
      mark_class(112, 127, ptnc_pkg::CLS_GREEN);
      mark_class(160, 191, ptnc_pkg::CLS_RED);
      mark_class(192, 207, ptnc_pkg::CLS_BLUE);
      mark_class(208, 231, ptnc_pkg::CLS_RED);
      mark_class(224, 225, ptnc_pkg::CLS_BLUE);
      mark_class(240, 247, ptnc_pkg::CLS_BLUE);
      mark_class(248, 249, ptnc_pkg::CLS_RED);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_write(REG_SPARE, 32'h0000_005a);

      // Every entry is written before the first search; a few duplicates force ties.
      for (int i = 0; i < 256; i++) begin
         if (i == 0 || i == 254) begin
            fill_rgb[i] = 24'h000000;
         end else if (i == 255) begin
            fill_rgb[i] = 24'hffffff;
         end else if (i == 1) begin
            fill_rgb[i] = 24'hff0000;
         end else if (i == 2) begin
            fill_rgb[i] = 24'h00ff00;
         end else if (i == 3) begin
            fill_rgb[i] = 24'h0000ff;
         end else if (i == 150 || i == 250) begin
            fill_rgb[i] = fill_rgb[40];
         end else if (i >= 128 && i < 192) begin
            fill_rgb[i] = {coarse_level[$urandom_range(4)], coarse_level[$urandom_range(4)],
                           coarse_level[$urandom_range(4)]};
         end else begin
            fill_rgb[i] = 24'($urandom);
         end
         pending_q.push_back(write_req(8'(i), fill_rgb[i]));
      end

      pending_q.push_back(nearest_req(24'h000000));
      pending_q.push_back(nearest_req(24'hffffff));
      pending_q.push_back(nearest_req(24'hff0000));
      pending_q.push_back(nearest_req(fill_rgb[40]));
      pending_q.push_back(nearest_req(24'h808080));
      pending_q.push_back(tint_req(8'd0, 8'd0));
      pending_q.push_back(tint_req(8'd255, 8'd255));
      pending_q.push_back(tint_req(8'd1, 8'd2));
      pending_q.push_back(tint_req(PAIR_HIGH, PAIR_LOW));
      pending_q.push_back(noise_req(REQ_UNUSED));
      pending_q.push_back(write_req(8'd5, fill_rgb[40]));
      pending_q.push_back(nearest_req(fill_rgb[40]));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle_block();
         csr_write(REG_BLEND_PERCENT, 32'(phase_pct[ph]));
         csr_write(REG_ADDITIVE_MODE, 32'(phase_add[ph]));
         csr_write(REG_CLASS_MASK, 32'(phase_mask[ph]));
         if (ph == 0) begin
            pending_q.push_back(tint_req(PAIR_HIGH, PAIR_LOW));
            pending_q.push_back(tint_req(PAIR_LOW, PAIR_HIGH));
            pending_q.push_back(tint_req(PAIR_HIGH, PAIR_NEXT));
            pending_q.push_back(tint_req(PAIR_NEXT, PAIR_HIGH));
            pending_q.push_back(tint_req(PAIR_HIGH, 8'd79));
            pending_q.push_back(tint_req(PAIR_NEXT, PAIR_LOW));
            pending_q.push_back(tint_req(8'd0, 8'd255));
         end else if (ph == 3) begin
            pending_q.push_back(tint_req(8'd4, 8'd200));
            pending_q.push_back(tint_req(8'd5, 8'd200));
            pending_q.push_back(tint_req(8'd255, 8'd0));
            pending_q.push_back(tint_req(8'd224, 8'd3));
            pending_q.push_back(tint_req(8'd63, 8'd250));
         end
         repeat (PHASE_ITEMS) begin
            pick = int'($urandom_range(99));
            if (pick < 22) begin
               pending_q.push_back(write_req(8'($urandom), 24'($urandom)));
            end else if (pick < 60) begin
               case ($urandom_range(3))
                  0, 1: fore_pick = 8'($urandom);
                  2: fore_pick = pair_idx[$urandom_range(2)];
                  default: fore_pick = border_idx[$urandom_range(13)];
               endcase
               back_pick = ($urandom_range(9) < 7) ? 8'($urandom) : pair_idx[$urandom_range(2)];
               pending_q.push_back(tint_req(fore_pick, back_pick));
            end else if (pick < 96) begin
               case ($urandom_range(9))
                  0, 1, 2: rgb = {coarse_level[$urandom_range(4)], coarse_level[$urandom_range(4)],
                                  coarse_level[$urandom_range(4)]};
                  3, 4: rgb = palette_shadow[$urandom_range(255)];
                  default: rgb = 24'($urandom);
               endcase
               pending_q.push_back(nearest_req(rgb));
            end else begin
               pending_q.push_back(noise_req(REQ_UNUSED));
            end
         end
      end

      settle_block();
      if (due_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected color indices never arrived", due_q.size()));
      end
      $display("Coverage: %0d palette writes, %0d tint lookups, %0d nearest queries, %0d ignored",
               writes_taken, tints_taken, nearest_taken, ignored_taken);
      $display("Register settings exercised: %0d; results compared: %0d; mismatches: %0d",
               NUM_PHASES + 1, results_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #(TIMEOUT_CYCLES * 4);
      $display("Timeout with %0d results still pending", due_q.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
